### hw/rtl/tkb_pkg.sv
`timescale 1ns / 1ps

package tkb_pkg;

   localparam int SCORE_W       = 48;
   localparam int TAG_W         = 32;
   localparam int CMD_W         = 2;
   localparam int EIDX_W        = 4;
   localparam int SLOT_W        = 5;
   localparam int LEN_W         = 5;
   localparam int CNT_W         = 5;
   localparam int CSR_W         = 48;
   localparam int CSR_IDX_W     = 1;
   localparam int LAST_W        = 9;
   localparam int DEF_MAX_SLOTS = 16;

   localparam logic [SCORE_W-1:0] THRESHOLD_RST   = 48'd65536000;
   localparam logic [LEN_W-1:0]   LIST_LENGTH_RST = 5'd10;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_READ   = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD   = 1'b0,
      CSR_LIST_LENGTH = 1'b1
   } csr_reg_type;

   typedef enum logic {
      CMP_SCAN  = 1'b0,
      CMP_COUNT = 1'b1
   } cmp_mode_type;

   // Write controls from the sequencer to the slot store.
   typedef struct packed {
      logic wr_new;
      logic wr_shift;
      logic clear_all;
      logic trim;
   } store_ctl_type;

   typedef struct packed {
      logic                      inserted;
      logic [SLOT_W-1:0]         slot;
      logic [CNT_W-1:0]          found_count;
      logic                      best_valid;
      logic signed [SCORE_W-1:0] best_score;
      logic [TAG_W-1:0]          best_tag;
      logic                      read_valid;
      logic signed [SCORE_W-1:0] read_score;
      logic [TAG_W-1:0]          read_tag;
   } rsp_type;

   // Index of the last slot in use: the length clamped to 1..max_slots, minus one.
   function automatic logic [LAST_W-1:0] last_slot(input logic [LEN_W-1:0] len,
                                                   input logic [LAST_W-1:0] max_slots);
      logic [LAST_W-1:0] n;
      n = LAST_W'(len);
      if (n == '0) n = LAST_W'(1);
      if (n > max_slots) n = max_slots;
      return n - LAST_W'(1);
   endfunction

endpackage

### hw/rtl/tkb_ifs.sv
`timescale 1ns / 1ps

interface tkb_req_if;
   import tkb_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          cmd;
   logic signed [SCORE_W-1:0] score;
   logic [TAG_W-1:0]          sample_tag;
   logic [EIDX_W-1:0]         entry_index;

   modport source (output valid, cmd, score, sample_tag, entry_index, input ready);
   modport sink (input valid, cmd, score, sample_tag, entry_index, output ready);
endinterface

interface tkb_rsp_if;
   import tkb_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      inserted;
   logic [SLOT_W-1:0]         slot;
   logic [CNT_W-1:0]          found_count;
   logic                      best_valid;
   logic signed [SCORE_W-1:0] best_score;
   logic [TAG_W-1:0]          best_tag;
   logic                      read_valid;
   logic signed [SCORE_W-1:0] read_score;
   logic [TAG_W-1:0]          read_tag;

   modport source (output valid, inserted, slot, found_count, best_valid, best_score,
                   best_tag, read_valid, read_score, read_tag, input ready);
   modport sink (input valid, inserted, slot, found_count, best_valid, best_score,
                 best_tag, read_valid, read_score, read_tag, output ready);
endinterface

### hw/rtl/tkb_cmp.sv
`timescale 1ns / 1ps

module tkb_cmp (
   input  tkb_pkg::cmp_mode_type             mode,
   input  logic signed [tkb_pkg::SCORE_W-1:0] item_score,
   input  logic signed [tkb_pkg::SCORE_W-1:0] entry_score,
   input  logic signed [tkb_pkg::SCORE_W-1:0] threshold,
   output logic                               less
);
   import tkb_pkg::*;

   logic signed [SCORE_W-1:0] op_a;
   logic signed [SCORE_W-1:0] op_b;

   // While scanning, the new item is tested against a stored entry; while
   // counting, the stored entry is tested against the threshold.
   always_comb begin
      case (mode)
         CMP_SCAN: begin
            op_a = item_score;
            op_b = entry_score;
         end
         CMP_COUNT: begin
            op_a = entry_score;
            op_b = threshold;
         end
         default: begin
            op_a = entry_score;
            op_b = threshold;
         end
      endcase
   end

   assign less = op_a < op_b;

endmodule

### hw/rtl/tkb_store.sv
`timescale 1ns / 1ps

module tkb_store #(
   parameter int MaxSlots = tkb_pkg::DEF_MAX_SLOTS,
   parameter int IdxW     = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tkb_pkg::store_ctl_type             ctl,
   input  logic [IdxW-1:0]                    wr_addr,
   input  logic [IdxW-1:0]                    rd_addr,
   input  logic signed [tkb_pkg::SCORE_W-1:0] new_score,
   input  logic [tkb_pkg::TAG_W-1:0]          new_tag,
   input  logic [tkb_pkg::LAST_W-1:0]         keep_last,
   output logic signed [tkb_pkg::SCORE_W-1:0] rd_score_ff,
   output logic [tkb_pkg::TAG_W-1:0]          rd_tag_ff,
   output logic [MaxSlots-1:0]                valid_ff
);
   import tkb_pkg::*;

   logic signed [SCORE_W-1:0] score_mem [MaxSlots];
   logic [TAG_W-1:0]          tag_mem [MaxSlots];
   logic [MaxSlots-1:0]       valid_in;
   logic signed [SCORE_W-1:0] wr_score;
   logic [TAG_W-1:0]          wr_tag;
   logic [IdxW-1:0]           src_addr;
   logic                      mem_we;

   // A shift step copies the entry just read one slot further down.
   assign src_addr = IdxW'(wr_addr - 1'b1);
   assign mem_we   = ctl.wr_new | ctl.wr_shift;
   assign wr_score = ctl.wr_new ? new_score : rd_score_ff;
   assign wr_tag   = ctl.wr_new ? new_tag : rd_tag_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         score_mem[wr_addr] <= wr_score;
         tag_mem[wr_addr]   <= wr_tag;
      end
      rd_score_ff <= score_mem[rd_addr];
      rd_tag_ff   <= tag_mem[rd_addr];
   end

   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear_all) valid_in = '0;
      if (ctl.trim) begin
         for (int k = 0; k < MaxSlots; k++) begin
            if (LAST_W'(k) > keep_last) valid_in[k] = 1'b0;
         end
      end
      if (ctl.wr_new) valid_in[wr_addr] = 1'b1;
      if (ctl.wr_shift) valid_in[wr_addr] = valid_ff[src_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

### hw/rtl/top_k_best_list_with_threshold_count.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Carries
// req_ch    in   valid / ready  cmd, score, sample_tag, entry_index
// rsp_ch    out  valid / ready  inserted, slot, found_count, best and read entries
// csr_*     in   csr_wr_en      csr_index, csr_wdata (threshold, list_length)
//
// With n slots in use, an insert runs from acceptance to the result through a scan and
// a shift that together visit at most n slots, one write, a step that restarts the memory
// read, and a count pass of n slots, all through the one read port of the slot memory
// and the one shared comparator. An insert that is not taken skips the write. Read,
// clear and no-op items go straight to the count pass of n slots.
// Reset is synchronous and empties the list; the slot memory itself is not cleared.
// One item is in work at a time; req_ch.ready is low until its result is taken.

module top_k_best_list_with_threshold_count #(
   parameter int MaxSlots = tkb_pkg::DEF_MAX_SLOTS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   tkb_req_if.sink                              req_ch,
   tkb_rsp_if.source                            rsp_ch,
   input  logic                                 csr_wr_en,
   input  logic [tkb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tkb_pkg::CSR_W-1:0]            csr_wdata
);
   import tkb_pkg::*;

   localparam int IdxW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SCAN  = 7'b0000010,
      S_SHIFT = 7'b0000100,
      S_WRITE = 7'b0001000,
      S_PREP  = 7'b0010000,
      S_COUNT = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type                 state_ff, state_in;
   logic [IdxW-1:0]           idx_ff, idx_in;
   logic [IdxW-1:0]           j_ff, j_in;
   cmd_type                   cmd_ff, cmd_in;
   logic signed [SCORE_W-1:0] score_ff, score_in;
   logic [TAG_W-1:0]          tag_ff, tag_in;
   logic [EIDX_W-1:0]         eidx_ff, eidx_in;
   logic signed [SCORE_W-1:0] thr_ff, thr_in;
   logic [LEN_W-1:0]          len_ff, len_in;
   rsp_type                   res_ff, res_in;

   store_ctl_type             ctl;
   logic [IdxW-1:0]           wr_addr;
   logic [LAST_W-1:0]         keep_last;
   logic [IdxW-1:0]           last_idx;
   logic signed [SCORE_W-1:0] rd_score;
   logic [TAG_W-1:0]          rd_tag;
   logic [MaxSlots-1:0]       valid;
   logic                      cmp_lt;
   cmp_mode_type              cmp_mode;
   logic                      req_fire;
   logic                      cur_valid;

   assign last_idx  = IdxW'(last_slot(len_ff, LAST_W'(MaxSlots)));
   assign keep_last = last_slot(csr_wdata[LEN_W-1:0], LAST_W'(MaxSlots));
   assign req_fire  = req_ch.valid & req_ch.ready;
   assign cur_valid = valid[idx_ff];
   assign cmp_mode  = (state_ff == S_SCAN) ? CMP_SCAN : CMP_COUNT;

   tkb_cmp u_cmp (
      .mode        (cmp_mode),
      .item_score  (score_ff),
      .entry_score (rd_score),
      .threshold   (thr_ff),
      .less        (cmp_lt)
   );

   tkb_store #(
      .MaxSlots (MaxSlots),
      .IdxW     (IdxW)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .wr_addr     (wr_addr),
      .rd_addr     (idx_in),
      .new_score   (score_ff),
      .new_tag     (tag_ff),
      .keep_last   (keep_last),
      .rd_score_ff (rd_score),
      .rd_tag_ff   (rd_tag),
      .valid_ff    (valid)
   );

   // Configuration writes.
   always_comb begin
      thr_in = thr_ff;
      len_in = len_ff;
      if (csr_wr_en) begin
         case (csr_reg_type'(csr_index))
            CSR_THRESHOLD: begin
               thr_in = csr_wdata[SCORE_W-1:0];
            end
            CSR_LIST_LENGTH: begin
               len_in = csr_wdata[LEN_W-1:0];
            end
            default: begin
               thr_in = thr_ff;
            end
         endcase
      end
   end

   // Sequencer. The memory read address is the index that the next cycle
   // evaluates, so the registered read data always belongs to idx_ff.
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      j_in          = j_ff;
      cmd_in        = cmd_ff;
      score_in      = score_ff;
      tag_in        = tag_ff;
      eidx_in       = eidx_ff;
      res_in        = res_ff;
      wr_addr       = IdxW'(idx_ff + 1'b1);
      ctl.wr_new    = 1'b0;
      ctl.wr_shift  = 1'b0;
      ctl.clear_all = 1'b0;
      ctl.trim      = csr_wr_en && (csr_reg_type'(csr_index) == CSR_LIST_LENGTH);

      case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            if (req_fire) begin
               cmd_in   = cmd_type'(req_ch.cmd);
               score_in = req_ch.score;
               tag_in   = req_ch.sample_tag;
               eidx_in  = req_ch.entry_index;
               res_in   = '0;
               res_in.slot = SLOT_W'(MaxSlots);
               case (cmd_type'(req_ch.cmd))
                  CMD_INSERT: state_in = S_SCAN;
                  CMD_CLEAR: begin
                     ctl.clear_all = 1'b1;
                     state_in = S_COUNT;
                  end
                  default: state_in = S_COUNT;
               endcase
            end
         end
         S_SCAN: begin
            if (!cur_valid || cmp_lt) begin
               res_in.inserted = 1'b1;
               res_in.slot     = SLOT_W'(idx_ff);
               j_in            = idx_ff;
               if (idx_ff == last_idx) begin
                  state_in = S_WRITE;
               end else begin
                  idx_in   = IdxW'(last_idx - 1'b1);
                  state_in = S_SHIFT;
               end
            end else if (idx_ff == last_idx) begin
               state_in = S_PREP;
            end else begin
               idx_in = IdxW'(idx_ff + 1'b1);
            end
         end
         S_SHIFT: begin
            ctl.wr_shift = 1'b1;
            if (idx_ff == j_ff) begin
               state_in = S_WRITE;
            end else begin
               idx_in = IdxW'(idx_ff - 1'b1);
            end
         end
         S_WRITE: begin
            ctl.wr_new = 1'b1;
            wr_addr    = j_ff;
            state_in   = S_PREP;
         end
         S_PREP: begin
            // Starts the count read only after the new entry is in memory.
            idx_in   = '0;
            state_in = S_COUNT;
         end
         S_COUNT: begin
            if (cur_valid && cmp_lt) begin
               res_in.found_count = res_ff.found_count + 1'b1;
            end
            if (idx_ff == '0) begin
               res_in.best_valid = cur_valid;
               res_in.best_score = cur_valid ? rd_score : '0;
               res_in.best_tag   = cur_valid ? rd_tag : '0;
            end
            if (cmd_ff == CMD_READ && cur_valid && LAST_W'(eidx_ff) == LAST_W'(idx_ff)) begin
               res_in.read_valid = 1'b1;
               res_in.read_score = rd_score;
               res_in.read_tag   = rd_tag;
            end
            if (idx_ff == last_idx) begin
               state_in = S_OUT;
            end else begin
               idx_in = IdxW'(idx_ff + 1'b1);
            end
         end
         S_OUT: begin
            if (rsp_ch.ready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         thr_ff   <= THRESHOLD_RST;
         len_ff   <= LIST_LENGTH_RST;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         thr_ff   <= thr_in;
         len_ff   <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff     <= j_in;
      cmd_ff   <= cmd_in;
      score_ff <= score_in;
      tag_ff   <= tag_in;
      eidx_ff  <= eidx_in;
      res_ff   <= res_in;
   end

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = (state_ff == S_OUT);
   assign rsp_ch.inserted    = res_ff.inserted;
   assign rsp_ch.slot        = res_ff.slot;
   assign rsp_ch.found_count = res_ff.found_count;
   assign rsp_ch.best_valid  = res_ff.best_valid;
   assign rsp_ch.best_score  = res_ff.best_score;
   assign rsp_ch.best_tag    = res_ff.best_tag;
   assign rsp_ch.read_valid  = res_ff.read_valid;
   assign rsp_ch.read_score  = res_ff.read_score;
   assign rsp_ch.read_tag    = res_ff.read_tag;

`ifndef SYNTHESIS
   a_ready_excl_rsp: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !rsp_ch.valid)
      else $error("input ready while a result is pending");

   a_non_insert_counts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.cmd != CMD_INSERT) |=> state_ff == S_COUNT)
      else $error("non-insert item did not go straight to the count pass");

   a_shift_above_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHIFT |-> (idx_ff >= j_ff && idx_ff < last_idx))
      else $error("shift step outside the insert slot range");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import tkb_pkg::*;

   localparam int SLOTS = DEF_MAX_SLOTS;
   localparam int LIMIT = 400000;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 128;
   localparam int TAIL_CYCLES = 3 * SLOTS + 12;

   localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
   localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

   typedef struct packed {
      cmd_type                   cmd;
      logic signed [SCORE_W-1:0] score;
      logic [TAG_W-1:0]          sample_tag;
      logic [EIDX_W-1:0]         entry_index;
   } sample_req_type;

   typedef struct packed {
      cmd_type                   cmd;
      logic signed [SCORE_W-1:0] score;
      logic [TAG_W-1:0]          sample_tag;
      logic [EIDX_W-1:0]         entry_index;
      logic                      typed;
      rsp_type                   want;
   } dir_row_type;

   typedef struct {
      bit      typed;
      rsp_type want;
   } typed_due_type;

   // Status of an empty list: nothing inserted, nothing read.
   localparam rsp_type EMPTY_RSP = '{inserted: 1'b0, slot: SLOT_W'(SLOTS),
      found_count: '0, best_valid: 1'b0, best_score: '0, best_tag: '0,
      read_valid: 1'b0, read_score: '0, read_tag: '0};

   // First entry into an empty list, scoring above the reset threshold.
   localparam rsp_type FIRST_MAX_RSP = '{inserted: 1'b1, slot: '0,
      found_count: '0, best_valid: 1'b1, best_score: SCORE_MAX, best_tag: 32'hFFFF_FFFF,
      read_valid: 1'b0, read_score: '0, read_tag: '0};

   localparam int DIR_COUNT = 22;
   localparam dir_row_type DIR_ROWS [DIR_COUNT] = '{
      '{CMD_NOP,    48'sd0,           32'h0000_0000, 4'd0,  1'b1, EMPTY_RSP},
      '{CMD_CLEAR,  48'sd0,           32'h0000_0000, 4'd0,  1'b1, EMPTY_RSP},
      '{CMD_INSERT, SCORE_MAX,        32'hFFFF_FFFF, 4'd0,  1'b1, FIRST_MAX_RSP},
      '{CMD_INSERT, SCORE_MIN,        32'h0000_0000, 4'd15, 1'b0, '0},
      '{CMD_INSERT, 48'sd0,           32'h0000_0001, 4'd0,  1'b0, '0},
      '{CMD_INSERT, -48'sd1,          32'h0000_0002, 4'd0,  1'b0, '0},
      '{CMD_INSERT, 48'sd0,           32'h0000_0003, 4'd0,  1'b0, '0},
      '{CMD_INSERT, 48'sd1,           32'h0000_0004, 4'd0,  1'b0, '0},
      '{CMD_INSERT, 48'sd65536000,    32'h0000_0005, 4'd0,  1'b0, '0},
      '{CMD_INSERT, 48'sd65535999,    32'h0000_0006, 4'd0,  1'b0, '0},
      '{CMD_INSERT, SCORE_MAX,        32'h0000_0007, 4'd0,  1'b0, '0},
      '{CMD_INSERT, SCORE_MAX,        32'h0000_0008, 4'd0,  1'b0, '0},
      '{CMD_INSERT, SCORE_MAX,        32'h0000_0009, 4'd0,  1'b0, '0},
      '{CMD_INSERT, SCORE_MIN,        32'h0000_000A, 4'd0,  1'b0, '0},
      '{CMD_READ,   48'sd0,           32'h0000_0000, 4'd0,  1'b0, '0},
      '{CMD_READ,   SCORE_MAX,        32'hFFFF_FFFF, 4'd9,  1'b0, '0},
      '{CMD_READ,   48'sd0,           32'h0000_0000, 4'd4,  1'b0, '0},
      '{CMD_NOP,    SCORE_MIN,        32'hFFFF_FFFF, 4'd15, 1'b0, '0},
      '{CMD_CLEAR,  48'sd0,           32'h0000_0000, 4'd0,  1'b1, EMPTY_RSP},
      '{CMD_READ,   48'sd0,           32'h0000_0000, 4'd3,  1'b1, EMPTY_RSP},
      '{CMD_INSERT, 48'sh8000_0000_0001, 32'h5A5A_5A5A, 4'd0, 1'b0, '0},
      '{CMD_READ,   48'sd0,           32'h0000_0000, 4'd0,  1'b0, '0}
   };

   localparam int PHASE_LEN [PHASES] = '{16, 0, 1, 31, 5, 17, 3, 10};

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;

   tkb_req_if req_ch ();
   tkb_rsp_if rsp_ch ();

   top_k_best_list_with_threshold_count dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the list and its registers.
   logic signed [SCORE_W-1:0] exp_score [SLOTS];
   logic [TAG_W-1:0]          exp_tag [SLOTS];
   bit                        exp_full [SLOTS];
   bit                        exp_known [SLOTS];
   logic signed [SCORE_W-1:0] exp_threshold;
   logic [LEN_W-1:0]          exp_length;

   rsp_type       status_due_q [$];
   typed_due_type typed_due_q [$];
   int            fail_count = 0;
   int            rsp_stall = 0;
   bit            idling_on = 1'b1;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   initial begin
      repeat (LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   function automatic int slots_in_use();
      int n;
      n = int'(exp_length);
      if (n < 1) n = 1;
      if (n > SLOTS) n = SLOTS;
      return n;
   endfunction

   // Applies one item to the shadow list and returns the status it should report.
   function automatic rsp_type next_list_status(sample_req_type it);
      rsp_type r;
      int n;
      int pos;
      int cnt;
      int k;
      r = EMPTY_RSP;
      n = slots_in_use();
      pos = n;
      cnt = 0;
      case (it.cmd)
         CMD_INSERT: begin
            for (k = 0; k < n; k++) begin
               if (pos == n && (!exp_full[k] || $signed(it.score) < $signed(exp_score[k])))
                  pos = k;
            end
            if (pos < n) begin
               for (k = n - 1; k > pos; k--) begin
                  exp_score[k] = exp_score[k-1];
                  exp_tag[k]   = exp_tag[k-1];
                  exp_full[k]  = exp_full[k-1];
                  exp_known[k] = exp_known[k-1];
               end
               exp_score[pos] = it.score;
               exp_tag[pos]   = it.sample_tag;
               exp_full[pos]  = 1'b1;
               exp_known[pos] = 1'b1;
               r.inserted = 1'b1;
               r.slot = SLOT_W'(pos);
            end
         end
         CMD_READ: begin
            if (int'(it.entry_index) < n && exp_full[it.entry_index]) begin
               r.read_valid = 1'b1;
               r.read_score = exp_score[it.entry_index];
               r.read_tag   = exp_tag[it.entry_index];
            end
         end
         CMD_CLEAR: begin
            for (k = 0; k < SLOTS; k++) exp_full[k] = 1'b0;
         end
         default: ;
      endcase
      for (k = 0; k < n; k++) begin
         if (exp_full[k] && $signed(exp_score[k]) < $signed(exp_threshold)) cnt++;
      end
      r.found_count = CNT_W'(cnt);
      r.best_valid = exp_full[0];
      if (exp_full[0]) begin
         r.best_score = exp_score[0];
         r.best_tag   = exp_tag[0];
      end
      return r;
   endfunction

   // Scores cluster on a few values and around the threshold so that ties and
   // threshold crossings are common.
   function automatic logic signed [SCORE_W-1:0] rand_score();
      logic signed [SCORE_W-1:0] s;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: s = SCORE_MIN;
               1: s = SCORE_MAX;
               2: s = '0;
               default: s = -48'sd1;
            endcase
         end
         1, 2, 3: begin
            s = $signed(SCORE_W'($urandom_range(0, 6))) - 48'sd3;
            s = s <<< 16;
         end
         4, 5: s = exp_threshold + $signed(SCORE_W'($urandom_range(0, 8))) - 48'sd4;
         default: s = SCORE_W'({$urandom, $urandom});
      endcase
      return s;
   endfunction

   function automatic sample_req_type rand_sample();
      sample_req_type it;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 62) it.cmd = CMD_INSERT;
      else if (pick < 90) it.cmd = CMD_READ;
      else if (pick < 92) it.cmd = CMD_CLEAR;
      else it.cmd = CMD_NOP;
      it.score = rand_score();
      it.sample_tag = $urandom;
      it.entry_index = EIDX_W'($urandom_range(0, SLOTS - 1));
      // A slot whose memory was never written is not read.
      if (it.cmd == CMD_READ && !exp_known[it.entry_index]) it.cmd = CMD_NOP;
      return it;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   task automatic compare_status(rsp_type want, rsp_type got);
      check_field("inserted", 64'(want.inserted), 64'(got.inserted));
      check_field("slot", 64'(want.slot), 64'(got.slot));
      check_field("found_count", 64'(want.found_count), 64'(got.found_count));
      check_field("best_valid", 64'(want.best_valid), 64'(got.best_valid));
      check_field("best_score", 64'(want.best_score), 64'(got.best_score));
      check_field("best_tag", 64'(want.best_tag), 64'(got.best_tag));
      check_field("read_valid", 64'(want.read_valid), 64'(got.read_valid));
      check_field("read_score", 64'(want.read_score), 64'(got.read_score));
      check_field("read_tag", 64'(want.read_tag), 64'(got.read_tag));
   endtask

   always @(posedge clock) begin
      sample_req_type it;
      typed_due_type  td;
      rsp_type        pred;
      rsp_type        got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            it.cmd = cmd_type'(req_ch.cmd);
            it.score = req_ch.score;
            it.sample_tag = req_ch.sample_tag;
            it.entry_index = req_ch.entry_index;
            pred = next_list_status(it);
            td.typed = 1'b0;
            td.want = pred;
            if (typed_due_q.size() != 0) td = typed_due_q.pop_front();
            status_due_q.push_back(td.typed ? td.want : pred);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.inserted = rsp_ch.inserted;
            got.slot = rsp_ch.slot;
            got.found_count = rsp_ch.found_count;
            got.best_valid = rsp_ch.best_valid;
            got.best_score = rsp_ch.best_score;
            got.best_tag = rsp_ch.best_tag;
            got.read_valid = rsp_ch.read_valid;
            got.read_score = rsp_ch.read_score;
            got.read_tag = rsp_ch.read_tag;
            if (status_due_q.size() == 0) begin
               $error("result item arrived with no expectation pending");
               fail_count++;
            end else begin
               compare_status(status_due_q.pop_front(), got);
            end
            rsp_stall = idling_on ? $urandom_range(0, 6) : 0;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Ends on a rising edge; valid stays high after the handshake.
   task automatic send_item(sample_req_type it, bit typed, rsp_type want);
      int gap;
      typed_due_type td;
      gap = idling_on ? $urandom_range(0, 6) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd <= it.cmd;
      req_ch.score <= it.score;
      req_ch.sample_tag <= it.sample_tag;
      req_ch.entry_index <= it.entry_index;
      td.typed = typed;
      td.want = want;
      typed_due_q.push_back(td);
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (status_due_q.size() != 0) @(negedge clock);
   endtask

   // Writes both registers; the block is idle whenever this runs.
   task automatic write_config(logic signed [SCORE_W-1:0] thr, logic [LEN_W-1:0] len);
      logic [CSR_W-1:0] word;
      int k;
      word = CSR_W'({$urandom, $urandom});
      word[LEN_W-1:0] = len;
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_THRESHOLD;
      csr_wdata <= thr;
      @(negedge clock);
      csr_index <= CSR_LIST_LENGTH;
      csr_wdata <= word;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      exp_threshold = thr;
      exp_length = len;
      for (k = slots_in_use(); k < SLOTS; k++) exp_full[k] = 1'b0;
   endtask

   initial begin
      sample_req_type it;
      logic signed [SCORE_W-1:0] thr;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_THRESHOLD;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_NOP;
      req_ch.score = '0;
      req_ch.sample_tag = '0;
      req_ch.entry_index = '0;
      rsp_ch.ready = 1'b0;
      exp_threshold = THRESHOLD_RST;
      exp_length = LIST_LENGTH_RST;
      for (int k = 0; k < SLOTS; k++) begin
         exp_score[k] = '0;
         exp_tag[k] = '0;
         exp_full[k] = 1'b0;
         exp_known[k] = 1'b0;
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed items under the reset configuration.
      for (int r = 0; r < DIR_COUNT; r++) begin
         it.cmd = DIR_ROWS[r].cmd;
         it.score = DIR_ROWS[r].score;
         it.sample_tag = DIR_ROWS[r].sample_tag;
         it.entry_index = DIR_ROWS[r].entry_index;
         send_item(it, DIR_ROWS[r].typed, DIR_ROWS[r].want);
      end

      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         case (p)
            1: thr = SCORE_MIN;
            2: thr = SCORE_MAX;
            3: thr = THRESHOLD_RST;
            5: thr = '0;
            default: thr = rand_score();
         endcase
         write_config(thr, LEN_W'(PHASE_LEN[p]));
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 32 == 0) idling_on = ($urandom_range(0, 3) != 0);
            // Let the list go fully quiet once in the middle of each phase.
            if (i == PHASE_ITEMS / 2) wait_drained();
            send_item(rand_sample(), 1'b0, EMPTY_RSP);
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (status_due_q.size() != 0) begin
         $error("%0d expected result items never arrived", status_due_q.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
